[src/dfma_pkg.sv]
// dfma_pkg: request kinds, status codes and the slot pick record
// shared by the descriptor free map allocator modules
// no dependencies
package dfma_pkg;

  localparam int SLOT_W = 6;

  typedef enum logic [1:0] {
    KIND_ALLOC = 2'd0,
    KIND_CHAIN = 2'd1,
    KIND_FREE  = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOSLOT  = 2'd1,
    ST_INVALID = 2'd2,
    ST_DOUBLE  = 2'd3
  } status_t;

  typedef struct packed {
    logic              any_free;
    logic              three_free;
    logic [SLOT_W-1:0] first;
    logic [SLOT_W-1:0] second;
    logic [SLOT_W-1:0] third;
  } pick_t;

endpackage

[src/dfma_if.sv]
// dfma_req_if and dfma_rsp_if: valid/ready channels of the allocator
// depends on nothing but the field widths of the allocator
interface dfma_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] slot_to_release;

  modport source (output valid, kind, slot_to_release, input ready);
  modport sink   (input valid, kind, slot_to_release, output ready);
endinterface

interface dfma_rsp_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [5:0] first_slot;
  logic [5:0] second_slot;
  logic [5:0] third_slot;

  modport source (output valid, status, first_slot, second_slot, third_slot, input ready);
  modport sink   (input valid, status, first_slot, second_slot, third_slot, output ready);
endinterface

[src/dfma_pick.sv]
// dfma_pick: finds the three lowest free slots of the free map and the maps left
// after taking one or three of them
// depends on dfma_pkg
module dfma_pick #(
  parameter int SLOT_COUNT = 8
) (
  input  logic [SLOT_COUNT-1:0] free_map,
  output dfma_pkg::pick_t       pick,
  output logic [SLOT_COUNT-1:0] map_after_one,
  output logic [SLOT_COUNT-1:0] map_after_three
);

  logic [SLOT_COUNT-1:0] oh0;
  logic [SLOT_COUNT-1:0] oh1;
  logic [SLOT_COUNT-1:0] oh2;
  logic [SLOT_COUNT-1:0] m1;
  logic [SLOT_COUNT-1:0] m2;

  function automatic logic [dfma_pkg::SLOT_W-1:0] encode(logic [SLOT_COUNT-1:0] oh);
    logic [dfma_pkg::SLOT_W-1:0] r;
    r = '0;
    for (int s = 0; s < SLOT_COUNT; s++) begin
      if (oh[s]) begin
        r = r | dfma_pkg::SLOT_W'(s);
      end
    end
    return r;
  endfunction

  always_comb begin
    oh0 = free_map & (~free_map + SLOT_COUNT'(1));
    m1  = free_map & ~oh0;
    oh1 = m1 & (~m1 + SLOT_COUNT'(1));
    m2  = m1 & ~oh1;
    oh2 = m2 & (~m2 + SLOT_COUNT'(1));

    pick.any_free   = |free_map;
    pick.three_free = |m2;
    pick.first      = encode(oh0);
    pick.second     = encode(oh1);
    pick.third      = encode(oh2);

    map_after_one   = m1;
    map_after_three = m2 & ~oh2;
  end

endmodule

[src/descriptor_free_map_allocator_unit.sv]
// Descriptor free map allocator: one free bit per slot, all set after reset.
// A request is held in an input register, then resolved against the free map by
// the lowest-free-slot pick logic, which writes the result register and the map
// together, so a result passes the input register and then the result register;
// one request is taken every cycle while results are being taken, since the map
// update for one request lands at the same edge its result is registered.
// depends on dfma_pkg, dfma_if and dfma_pick
module descriptor_free_map_allocator_unit #(
  parameter int SLOT_COUNT = 8
) (
  input  logic              clk,
  input  logic              rst,
  dfma_req_if.sink          req,
  dfma_rsp_if.source        rsp
);

  localparam int IDX_W = $clog2(SLOT_COUNT);

  logic                  in_valid;
  logic [1:0]            kind_q;
  logic [7:0]            slot_q;
  logic [SLOT_COUNT-1:0] free_map;
  logic [SLOT_COUNT-1:0] free_map_next;
  logic [SLOT_COUNT-1:0] map_after_one;
  logic [SLOT_COUNT-1:0] map_after_three;
  dfma_pkg::pick_t       pick;
  logic                  advance;

  logic [1:0]                  status_next;
  logic [dfma_pkg::SLOT_W-1:0] first_next;
  logic [dfma_pkg::SLOT_W-1:0] second_next;
  logic [dfma_pkg::SLOT_W-1:0] third_next;

  dfma_pick #(.SLOT_COUNT(SLOT_COUNT)) u_pick (
    .free_map        (free_map),
    .pick            (pick),
    .map_after_one   (map_after_one),
    .map_after_three (map_after_three)
  );

  assign advance   = in_valid && (!rsp.valid || rsp.ready);
  assign req.ready = !in_valid || advance;

  always_comb begin
    status_next   = dfma_pkg::ST_OK;
    first_next    = '0;
    second_next   = '0;
    third_next    = '0;
    free_map_next = free_map;
    unique case (dfma_pkg::kind_t'(kind_q))
      dfma_pkg::KIND_ALLOC: begin
        if (pick.any_free) begin
          free_map_next = map_after_one;
          first_next    = pick.first;
        end else begin
          status_next = dfma_pkg::ST_NOSLOT;
        end
      end
      dfma_pkg::KIND_CHAIN: begin
        if (pick.three_free) begin
          free_map_next = map_after_three;
          first_next    = pick.first;
          second_next   = pick.second;
          third_next    = pick.third;
        end else begin
          status_next = dfma_pkg::ST_NOSLOT;
        end
      end
      dfma_pkg::KIND_FREE: begin
        if (slot_q >= 8'(SLOT_COUNT)) begin
          status_next = dfma_pkg::ST_INVALID;
        end else if (free_map[slot_q[IDX_W-1:0]]) begin
          status_next = dfma_pkg::ST_DOUBLE;
        end else begin
          free_map_next = free_map | (SLOT_COUNT'(1) << slot_q[IDX_W-1:0]);
        end
      end
      default: begin
        status_next = dfma_pkg::ST_INVALID;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      rsp.valid <= 1'b0;
      free_map  <= '1;
    end else begin
      if (req.valid && req.ready) begin
        in_valid <= 1'b1;
      end else if (advance) begin
        in_valid <= 1'b0;
      end
      if (advance) begin
        rsp.valid <= 1'b1;
        free_map  <= free_map_next;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      kind_q <= req.kind;
      slot_q <= req.slot_to_release;
    end
    if (advance) begin
      rsp.status      <= status_next;
      rsp.first_slot  <= first_next;
      rsp.second_slot <= second_next;
      rsp.third_slot  <= third_next;
    end
  end

  a_chain_ascending: assert property (@(posedge clk) disable iff (rst)
    advance && kind_q == dfma_pkg::KIND_CHAIN && pick.three_free
      |-> pick.first < pick.second && pick.second < pick.third)
    else $error("chain slots not ascending");

  a_alloc_takes_one: assert property (@(posedge clk) disable iff (rst)
    advance && kind_q == dfma_pkg::KIND_ALLOC && pick.any_free
      |=> $countones(free_map) == $past($countones(free_map)) - 1)
    else $error("single allocate did not take exactly one slot");

  a_fail_slots_zero: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.status != dfma_pkg::ST_OK
      |-> rsp.first_slot == '0 && rsp.second_slot == '0 && rsp.third_slot == '0)
    else $error("slot fields set on failed request");

  a_held_request_kept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !advance |=> in_valid && $stable(kind_q) && $stable(slot_q))
    else $error("held request lost");

endmodule
